/* rtl/sqw_pkg.sv */
`timescale 1ns / 1ps

package sqw_pkg;

  typedef enum logic [2:0] {
    FUNC_CONTROL    = 3'd0,
    FUNC_SWEEP      = 3'd1,
    FUNC_TIMER_LOW  = 3'd2,
    FUNC_TIMER_HIGH = 3'd3,
    FUNC_ENABLE     = 3'd4,
    FUNC_TIMER_TICK = 3'd5,
    FUNC_QUARTER    = 3'd6,
    FUNC_HALF       = 3'd7
  } func_t;

  localparam logic [3:0] DECAY_TOP = 4'd15;

  // one row per duty setting, bit n is the output at sequencer step n
  localparam logic [3:0][7:0] DUTY_PATTERN = {
    8'b1111_1001,
    8'b0001_1110,
    8'b0000_0110,
    8'b0000_0010
  };

  typedef struct packed {
    logic [3:0] level;
    logic       length_active;
  } result_t;

  typedef struct packed {
    logic       tick;
    logic       restart;
    logic [3:0] param;
    logic       loop;
  } env_ctrl_t;

  function automatic logic [7:0] len_load_value(input logic [4:0] idx);
    logic [7:0] len;
    case (idx)
      5'd0:  len = 8'd10;
      5'd1:  len = 8'd254;
      5'd2:  len = 8'd20;
      5'd3:  len = 8'd2;
      5'd4:  len = 8'd40;
      5'd5:  len = 8'd4;
      5'd6:  len = 8'd80;
      5'd7:  len = 8'd6;
      5'd8:  len = 8'd160;
      5'd9:  len = 8'd8;
      5'd10: len = 8'd60;
      5'd11: len = 8'd10;
      5'd12: len = 8'd14;
      5'd13: len = 8'd12;
      5'd14: len = 8'd26;
      5'd15: len = 8'd14;
      5'd16: len = 8'd12;
      5'd17: len = 8'd16;
      5'd18: len = 8'd24;
      5'd19: len = 8'd18;
      5'd20: len = 8'd48;
      5'd21: len = 8'd20;
      5'd22: len = 8'd96;
      5'd23: len = 8'd22;
      5'd24: len = 8'd192;
      5'd25: len = 8'd24;
      5'd26: len = 8'd72;
      5'd27: len = 8'd26;
      5'd28: len = 8'd16;
      5'd29: len = 8'd28;
      5'd30: len = 8'd32;
      5'd31: len = 8'd30;
      default: len = 8'd0;
    endcase
    return len;
  endfunction

endpackage

/* rtl/sqw_if.sv */
`timescale 1ns / 1ps

interface sqw_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface sqw_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] level;
  logic       length_active;

  modport source (output valid, output level, output length_active, input ready);
  modport sink   (input valid, input level, input length_active, output ready);
endinterface

/* rtl/sqw_envelope.sv */
`timescale 1ns / 1ps

module sqw_envelope import sqw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  env_ctrl_t  ctrl,
  output logic [3:0] decay_next
);

  logic       start;
  logic       start_next;
  logic [3:0] divider;
  logic [3:0] divider_next;
  logic [3:0] decay;

  always_comb begin
    start_next   = start;
    divider_next = divider;
    decay_next   = decay;
    if (ctrl.restart) begin
      start_next = 1'b1;
    end
    if (ctrl.tick) begin
      if (start) begin
        start_next   = 1'b0;
        decay_next   = DECAY_TOP;
        divider_next = ctrl.param;
      end else if (divider == 4'd0) begin
        if (decay != 4'd0) begin
          decay_next = decay - 4'd1;
        end else if (ctrl.loop) begin
          decay_next = DECAY_TOP;
        end
        divider_next = ctrl.param;
      end else begin
        divider_next = divider - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start   <= 1'b0;
      divider <= 4'd0;
      decay   <= 4'd0;
    end else begin
      start   <= start_next;
      divider <= divider_next;
      decay   <= decay_next;
    end
  end

endmodule

/* rtl/sqw_sweep.sv */
`timescale 1ns / 1ps

module sqw_sweep (
  input  logic [10:0] period,
  input  logic [2:0]  amount,
  input  logic        down,
  output logic [10:0] target,
  output logic        mute
);

  logic [10:0] change;
  logic [11:0] sum;
  logic [10:0] diff;

  // change never exceeds period, so the downward target cannot go negative
  assign change = period >> amount;
  assign sum    = {1'b0, period} + {1'b0, change};
  assign diff   = period - change;
  assign target = down ? diff : sum[10:0];
  assign mute   = (period < 11'd8) || (!down && sum[11]);

endmodule

/* rtl/sqw_out_buf.sv */
`timescale 1ns / 1ps

module sqw_out_buf import sqw_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  result_t          push_data,
  output logic             ready,
  sqw_out_if.source        result
);

  result_t head;
  result_t skid;
  logic    head_valid;
  logic    skid_valid;
  logic    pop;

  assign pop                  = head_valid && result.ready;
  assign ready                = !skid_valid;
  assign result.valid         = head_valid;
  assign result.level         = head.level;
  assign result.length_active = head.length_active;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        head       <= skid;
        skid_valid <= 1'b0;
      end else if (push) begin
        head <= push_data;
      end else begin
        head_valid <= 1'b0;
      end
    end else if (push) begin
      if (!head_valid) begin
        head       <= push_data;
        head_valid <= 1'b1;
      end else begin
        skid       <= push_data;
        skid_valid <= 1'b1;
      end
    end
  end

endmodule

/* rtl/square_wave_sound_channel.sv */
`timescale 1ns / 1ps

// Square-wave sound channel: each input word is a register write or a tick,
// and every accepted word yields one result word with the channel level and
// the length status after that word. One word is taken per cycle while ready
// is high, and its result is registered in the output buffer; all channel state
// updates in the cycle a word is accepted. A two-entry output buffer lets the
// channel take new words while a result waits; input ready drops only when both
// entries are held by a stalled consumer.
module square_wave_sound_channel import sqw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  sqw_in_if.sink    item,
  sqw_out_if.source result
);

  logic        acc;
  func_t       func;
  logic [7:0]  value;

  logic        channel_on, channel_on_next;
  logic [1:0]  duty_select, duty_select_next;
  logic [2:0]  duty_step, duty_step_next;
  logic [10:0] period_count, period_count_next;
  logic [10:0] period_value, period_value_next;
  logic [7:0]  length_count, length_count_next;
  logic        length_running, length_running_next;
  logic        env_loop, env_loop_next;
  logic        env_constant, env_constant_next;
  logic [3:0]  env_param, env_param_next;
  logic        sweep_on, sweep_on_next;
  logic [2:0]  sweep_rate, sweep_rate_next;
  logic        sweep_down, sweep_down_next;
  logic [2:0]  sweep_amount, sweep_amount_next;
  logic        sweep_reload_flag, sweep_reload_flag_next;
  logic [2:0]  sweep_divider_count, sweep_divider_count_next;
  logic        sweep_silenced, sweep_silenced_next;

  logic [10:0] sweep_target;
  logic        target_mutes;
  env_ctrl_t   env_ctrl;
  logic [3:0]  env_decay_next;
  logic        duty_bit;
  result_t     push_data;
  logic        buf_ready;

  assign item.ready = buf_ready;
  assign acc        = item.valid && item.ready;
  assign func       = func_t'(item.func);
  assign value      = item.value;

  sqw_sweep u_sweep (
    .period (period_value),
    .amount (sweep_amount),
    .down   (sweep_down),
    .target (sweep_target),
    .mute   (target_mutes)
  );

  assign env_ctrl.tick    = acc && (func == FUNC_QUARTER || func == FUNC_HALF);
  assign env_ctrl.restart = acc && (func == FUNC_TIMER_HIGH);
  assign env_ctrl.param   = env_param;
  assign env_ctrl.loop    = env_loop;

  sqw_envelope u_envelope (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (env_ctrl),
    .decay_next (env_decay_next)
  );

  always_comb begin
    channel_on_next          = channel_on;
    duty_select_next         = duty_select;
    duty_step_next           = duty_step;
    period_count_next        = period_count;
    period_value_next        = period_value;
    length_count_next        = length_count;
    length_running_next      = length_running;
    env_loop_next            = env_loop;
    env_constant_next        = env_constant;
    env_param_next           = env_param;
    sweep_on_next            = sweep_on;
    sweep_rate_next          = sweep_rate;
    sweep_down_next          = sweep_down;
    sweep_amount_next        = sweep_amount;
    sweep_reload_flag_next   = sweep_reload_flag;
    sweep_divider_count_next = sweep_divider_count;
    sweep_silenced_next      = sweep_silenced;
    if (acc) begin
      case (func)
        FUNC_CONTROL: begin
          duty_select_next    = value[7:6];
          env_loop_next       = value[5];
          length_running_next = !value[5];
          env_constant_next   = value[4];
          env_param_next      = value[3:0];
        end
        FUNC_SWEEP: begin
          sweep_on_next          = value[7];
          sweep_rate_next        = value[6:4];
          sweep_down_next        = value[3];
          sweep_amount_next      = value[2:0];
          sweep_reload_flag_next = 1'b1;
        end
        FUNC_TIMER_LOW: begin
          period_value_next = {period_value[10:8], value};
        end
        FUNC_TIMER_HIGH: begin
          period_value_next = {value[2:0], period_value[7:0]};
          duty_step_next    = 3'd0;
          if (channel_on) begin
            length_count_next = len_load_value(value[7:3]);
          end
        end
        FUNC_ENABLE: begin
          channel_on_next = value[0];
          if (!value[0]) begin
            length_count_next = 8'd0;
          end
        end
        FUNC_TIMER_TICK: begin
          if (period_count == 11'd0) begin
            period_count_next = period_value;
            duty_step_next    = duty_step + 3'd1;
          end else begin
            period_count_next = period_count - 11'd1;
          end
        end
        FUNC_QUARTER: begin
          // envelope only, handled in u_envelope
        end
        FUNC_HALF: begin
          if (length_running && length_count != 8'd0) begin
            length_count_next = length_count - 8'd1;
          end
          sweep_silenced_next = target_mutes;
          if (sweep_divider_count == 3'd0 && sweep_on && sweep_amount != 3'd0 &&
              !target_mutes) begin
            period_value_next = sweep_target;
          end
          if (sweep_divider_count == 3'd0 || sweep_reload_flag) begin
            sweep_divider_count_next = sweep_rate;
            sweep_reload_flag_next   = 1'b0;
          end else begin
            sweep_divider_count_next = sweep_divider_count - 3'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign duty_bit = DUTY_PATTERN[duty_select_next][duty_step_next];

  always_comb begin
    if (!channel_on_next || sweep_silenced_next || length_count_next == 8'd0 ||
        !duty_bit) begin
      push_data.level = 4'd0;
    end else begin
      push_data.level = env_constant_next ? env_param_next : env_decay_next;
    end
    push_data.length_active = (length_count_next != 8'd0);
  end

  sqw_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (acc),
    .push_data (push_data),
    .ready     (buf_ready),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_on          <= 1'b0;
      duty_select         <= 2'd0;
      duty_step           <= 3'd0;
      period_count        <= 11'd0;
      period_value        <= 11'd0;
      length_count        <= 8'd0;
      length_running      <= 1'b0;
      env_loop            <= 1'b0;
      env_constant        <= 1'b0;
      env_param           <= 4'd0;
      sweep_on            <= 1'b0;
      sweep_rate          <= 3'd0;
      sweep_down          <= 1'b0;
      sweep_amount        <= 3'd0;
      sweep_reload_flag   <= 1'b0;
      sweep_divider_count <= 3'd0;
      sweep_silenced      <= 1'b0;
    end else begin
      channel_on          <= channel_on_next;
      duty_select         <= duty_select_next;
      duty_step           <= duty_step_next;
      period_count        <= period_count_next;
      period_value        <= period_value_next;
      length_count        <= length_count_next;
      length_running      <= length_running_next;
      env_loop            <= env_loop_next;
      env_constant        <= env_constant_next;
      env_param           <= env_param_next;
      sweep_on            <= sweep_on_next;
      sweep_rate          <= sweep_rate_next;
      sweep_down          <= sweep_down_next;
      sweep_amount        <= sweep_amount_next;
      sweep_reload_flag   <= sweep_reload_flag_next;
      sweep_divider_count <= sweep_divider_count_next;
      sweep_silenced      <= sweep_silenced_next;
    end
  end

  a_silent_when_length_zero: assert property (@(posedge clk) disable iff (rst)
    acc && !push_data.length_active |-> push_data.level == 4'd0)
    else $error("nonzero level with length counter at zero");

  a_disable_clears_length: assert property (@(posedge clk) disable iff (rst)
    acc && func == FUNC_ENABLE && !value[0] |=> length_count == 8'd0)
    else $error("length counter not cleared by disable");

  a_mute_only_on_half: assert property (@(posedge clk) disable iff (rst)
    !(acc && func == FUNC_HALF) |=> $stable(sweep_silenced))
    else $error("sweep mute changed outside a half frame");

  a_short_period_mutes: assert property (@(posedge clk) disable iff (rst)
    acc && func == FUNC_HALF && period_value < 11'd8 |=> sweep_silenced)
    else $error("short period did not mute the channel");

endmodule
